@@ src/psch_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package psch_pkg;

  localparam int DEF_MAX_PROCS = 16;
  localparam int ID_W = 16;
  localparam int BURST_W = 16;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 20;
  localparam int AVG_W = 28;
  localparam int FRAC_W = 8;

  // One stored job as it sits in the job memory.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } job_t;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

@@ src/priority_schedule_timing.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Loading: one request per cycle, busy stays low while jobs are collected.
// After the last request of a set, the block is busy with selection passes through
// the single key comparator and then two divisions in the bit-serial divider.
// Rows come out one per pass, and the receiver cannot stall.
// Reset (rst, synchronous, active high) empties the job set and idles the block.
module priority_schedule_timing import psch_pkg::*; #(
  parameter int MAX_PROCS = DEF_MAX_PROCS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [ID_W-1:0]    job_id,
  input  wire logic [BURST_W-1:0] burst_length,
  input  wire logic [PRIO_W-1:0]  job_priority,
  input  wire logic               is_last,
  output logic                    result_valid,
  output logic [ID_W-1:0]         out_job_id,
  output logic [BURST_W-1:0]      out_burst,
  output logic [PRIO_W-1:0]       out_priority,
  output logic [TIME_W-1:0]       wait_time,
  output logic [TIME_W-1:0]       turnaround,
  output logic [AVG_W-1:0]        avg_wait_q8,
  output logic [AVG_W-1:0]        avg_turnaround_q8,
  output logic                    overflow,
  output logic                    row_last
);

  // Counter and index widths follow the capacity of the job memory.
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  // A running wait is a sum of at most MAX_PROCS bursts; the totals add up
  // at most MAX_PROCS such sums.
  localparam int WAIT_W = BURST_W + CNT_W;
  localparam int TOT_W  = WAIT_W + CNT_W;
  localparam int DVD_W  = TOT_W + FRAC_W;
  // The sort key is the priority with the arrival index below it, so the
  // selection order is stable: equal priorities leave in arrival order.
  localparam int KEY_W  = PRIO_W + IDX_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_ROW  = 5'b00100,
    ST_DIVW = 5'b01000,
    ST_DIVT = 5'b10000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [CNT_W-1:0]  issue_ptr;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              found;
  logic              have_last;
  logic [KEY_W-1:0]  last_key;
  logic [KEY_W-1:0]  best_key;
  job_t              best_job;
  logic [CNT_W-1:0]  rank;
  logic [WAIT_W-1:0] wait_acc;
  logic [TOT_W-1:0]  total_wait;
  logic [TOT_W-1:0]  total_turn;

  logic              accept;
  logic              wr_en;
  job_t              wr_data;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  job_t              rd_data;
  logic [CNT_W-1:0]  cnt_m1;
  logic [KEY_W-1:0]  cand_key;
  logic              take;
  logic              scan_end;
  logic              final_row;
  logic [WAIT_W-1:0] tat;
  logic [TOT_W-1:0]  tw_sum;
  logic [TOT_W-1:0]  tt_sum;
  logic [WAIT_W+TIME_W-1:0] wait_wide;
  logic [WAIT_W+TIME_W-1:0] tat_wide;
  logic              div_start;
  logic [DVD_W-1:0]  div_dividend;
  logic [DVD_W-1:0]  div_quot;
  logic [DVD_W+AVG_W-1:0] quot_wide;
  div_stat_t         div_stat;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  // A request that finds the memory full is not stored; it marks the set as overflowed.
  assign wr_en  = accept && (count < CNT_W'(MAX_PROCS));
  assign wr_data.id    = job_id;
  assign wr_data.burst = burst_length;
  assign wr_data.prio  = job_priority;

  // Each selection pass streams all stored jobs through one comparator and
  // keeps the smallest key that is larger than the key chosen last time.
  assign rd_en    = (state == ST_SCAN) && (issue_ptr < count);
  assign rd_addr  = issue_ptr[IDX_W-1:0];
  assign cnt_m1   = count - CNT_W'(1);
  assign cand_key = {rd_data.prio, cmp_idx};
  assign take     = cmp_vld && (!have_last || (cand_key > last_key)) &&
                    (!found || (cand_key < best_key));
  assign scan_end = cmp_vld && (cmp_idx == cnt_m1[IDX_W-1:0]);
  assign final_row = (rank == cnt_m1);

  // Running wait and turnaround of the job picked in this pass.
  assign tat    = wait_acc + {{CNT_W{1'b0}}, best_job.burst};
  assign tw_sum = total_wait + {{CNT_W{1'b0}}, wait_acc};
  assign tt_sum = total_turn + {{CNT_W{1'b0}}, tat};
  assign wait_wide = {{TIME_W{1'b0}}, wait_acc};
  assign tat_wide  = {{TIME_W{1'b0}}, tat};

  // The averages share one divider: the wait total is divided first, right
  // as the final pass ends, and the turnaround total as soon as it is free.
  assign div_start    = ((state == ST_ROW) && final_row) ||
                        ((state == ST_DIVW) && div_stat.done);
  assign div_dividend = (state == ST_ROW) ? {tw_sum, {FRAC_W{1'b0}}}
                                          : {total_turn, {FRAC_W{1'b0}}};
  assign quot_wide    = {{AVG_W{1'b0}}, div_quot};

  psch_store #(
    .DEPTH(MAX_PROCS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(count[IDX_W-1:0]),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  psch_div #(
    .DVD_W(DVD_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (count),
    .quotient(div_quot),
    .stat    (div_stat)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      dropped      <= 1'b0;
      issue_ptr    <= '0;
      cmp_vld      <= 1'b0;
      found        <= 1'b0;
      have_last    <= 1'b0;
      rank         <= '0;
      result_valid <= 1'b0;
    end else begin
      // Rows other than the final one leave right after their pass; the
      // final row waits for the second division.
      result_valid <= ((state == ST_ROW) && !final_row) ||
                      ((state == ST_DIVT) && div_stat.done);
      cmp_vld      <= rd_en;
      if (rd_en) begin
        issue_ptr <= issue_ptr + CNT_W'(1);
      end
      if (take) begin
        found <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (wr_en) begin
              count <= count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (is_last) begin
              state     <= ST_SCAN;
              issue_ptr <= '0;
              found     <= 1'b0;
              have_last <= 1'b0;
              rank      <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (scan_end) begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          issue_ptr    <= '0;
          found        <= 1'b0;
          have_last    <= 1'b1;
          rank         <= rank + CNT_W'(1);
          state        <= final_row ? ST_DIVW : ST_SCAN;
        end
        ST_DIVW: begin
          if (div_stat.done) begin
            state <= ST_DIVT;
          end
        end
        ST_DIVT: begin
          if (div_stat.done) begin
            count        <= '0;
            dropped      <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: selection results, sums and the result row.
  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (take) begin
      best_key <= cand_key;
      best_job <= rd_data;
    end
    if (accept && is_last) begin
      wait_acc   <= '0;
      total_wait <= '0;
      total_turn <= '0;
    end
    if (state == ST_ROW) begin
      last_key          <= best_key;
      wait_acc          <= tat;
      total_wait        <= tw_sum;
      total_turn        <= tt_sum;
      out_job_id        <= best_job.id;
      out_burst         <= best_job.burst;
      out_priority      <= best_job.prio;
      wait_time         <= wait_wide[TIME_W-1:0];
      turnaround        <= tat_wide[TIME_W-1:0];
      avg_wait_q8       <= '0;
      avg_turnaround_q8 <= '0;
      overflow          <= dropped;
      row_last          <= final_row;
    end
    if ((state == ST_DIVW) && div_stat.done) begin
      avg_wait_q8 <= quot_wide[AVG_W-1:0];
    end
    if ((state == ST_DIVT) && div_stat.done) begin
      avg_turnaround_q8 <= quot_wide[AVG_W-1:0];
    end
  end

  // The stored job count never passes the memory depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_PROCS))
    else $error("job count beyond capacity");

  // Rows only leave while a schedule is being worked on.
  a_row_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result row outside a schedule run");

  // The final row of a schedule hands the block back to loading.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (result_valid && row_last) |-> !busy)
    else $error("block still busy after final row");

  // Averages appear on the final row only.
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !row_last) |-> ((avg_wait_q8 == '0) && (avg_turnaround_q8 == '0)))
    else $error("average on a non-final row");

endmodule
`default_nettype wire

@@ src/psch_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psch_store import psch_pkg::*; #(
  parameter int DEPTH = DEF_MAX_PROCS,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire job_t             wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output job_t                  rd_data
);

  job_t mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ src/psch_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module psch_div import psch_pkg::*; #(
  parameter int DVD_W = 34,
  parameter int DVS_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic      [DVD_W-1:0] quotient,
  output div_stat_t             stat
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [STEP_W-1:0] steps;
  logic              busy;
  logic              done;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem, quo[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (steps == STEP_W'(1));
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (busy && (steps == STEP_W'(1))) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo   <= dividend;
      rem   <= '0;
      dvs   <= divisor;
      steps <= STEP_W'(DVD_W);
    end else if (busy) begin
      quo   <= {quo[DVD_W-2:0], fits};
      rem   <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      steps <= steps - STEP_W'(1);
    end
  end

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import psch_pkg::*;

  // The block holds DEF_MAX_PROCS jobs per set; later requests of the set are dropped.
  localparam int SLOTS = DEF_MAX_PROCS;
  // Random requests that actually land in the job store (dropped ones do not count).
  localparam int RANDOM_JOBS = 440;
  localparam int DIRECTED_N = 24;
  // Quiet time after the drain, longer than a full set of 16 keeps the block busy.
  localparam int SETTLE_CYCLES = 500;
  localparam int DRAIN_LIMIT = 5000;

  // One schedule row as the block presents it on its result ports.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  wait_t;
    logic [TIME_W-1:0]  tat;
    logic [AVG_W-1:0]   avg_wait;
    logic [AVG_W-1:0]   avg_tat;
    logic               ovf;
    logic               last;
  } sched_row_t;

  // One directed request. Where typed is set, the row is the whole schedule of a
  // single-job set and is written out by hand instead of being computed.
  typedef struct packed {
    job_t       job;
    logic       last;
    logic       typed;
    sched_row_t row;
  } stim_row_t;

  // Directed requests:
  //  - a single job with every field at its maximum, and one with every field at zero;
  //  - a four-job set with equal priorities that must keep their arrival order and a
  //    zero priority that jumps to the front;
  //  - a full set of sixteen maximum bursts, so waits and averages reach their largest
  //    values, followed by two dropped requests, the second of which closes the set.
  //    The overflow flag must show on every row, and the next set must start clean.
  localparam stim_row_t DIRECTED_REQS [DIRECTED_N] = '{
    '{'{16'hFFFF, 16'hFFFF, 8'hFF}, 1'b1, 1'b1,
      '{16'hFFFF, 16'hFFFF, 8'hFF, 20'h0, 20'h0FFFF, 28'h0, 28'h0FFFF00, 1'b0, 1'b1}},
    '{'{16'h0000, 16'h0000, 8'h00}, 1'b1, 1'b1,
      '{16'h0000, 16'h0000, 8'h00, 20'h0, 20'h0, 28'h0, 28'h0, 1'b0, 1'b1}},
    '{'{16'h0001, 16'd10, 8'd5}, 1'b0, 1'b0, '0},
    '{'{16'h0002, 16'd20, 8'd3}, 1'b0, 1'b0, '0},
    '{'{16'h0003, 16'd30, 8'd5}, 1'b0, 1'b0, '0},
    '{'{16'h0004, 16'd40, 8'd0}, 1'b1, 1'b0, '0},
    '{'{16'h0100, 16'hFFFF, 8'hFF}, 1'b0, 1'b0, '0},
    '{'{16'h0101, 16'hFFFF, 8'h00}, 1'b0, 1'b0, '0},
    '{'{16'h0102, 16'hFFFF, 8'h80}, 1'b0, 1'b0, '0},
    '{'{16'h0103, 16'hFFFF, 8'h00}, 1'b0, 1'b0, '0},
    '{'{16'h0104, 16'hFFFF, 8'hFF}, 1'b0, 1'b0, '0},
    '{'{16'h0105, 16'hFFFF, 8'h7F}, 1'b0, 1'b0, '0},
    '{'{16'h0106, 16'hFFFF, 8'h01}, 1'b0, 1'b0, '0},
    '{'{16'h0107, 16'hFFFF, 8'hFE}, 1'b0, 1'b0, '0},
    '{'{16'h0108, 16'hFFFF, 8'h00}, 1'b0, 1'b0, '0},
    '{'{16'h0109, 16'hFFFF, 8'hFF}, 1'b0, 1'b0, '0},
    '{'{16'h010A, 16'hFFFF, 8'h40}, 1'b0, 1'b0, '0},
    '{'{16'h010B, 16'hFFFF, 8'h40}, 1'b0, 1'b0, '0},
    '{'{16'h010C, 16'hFFFF, 8'h02}, 1'b0, 1'b0, '0},
    '{'{16'h010D, 16'hFFFF, 8'hFF}, 1'b0, 1'b0, '0},
    '{'{16'h010E, 16'hFFFF, 8'h00}, 1'b0, 1'b0, '0},
    '{'{16'h010F, 16'hFFFF, 8'h10}, 1'b0, 1'b0, '0},
    '{'{16'hDEAD, 16'h1234, 8'h00}, 1'b0, 1'b0, '0},
    '{'{16'hBEEF, 16'h4321, 8'h00}, 1'b1, 1'b0, '0}
  };

  // Every input starts at a known value; reset is held from time zero.
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [ID_W-1:0]    job_id = '0;
  logic [BURST_W-1:0] burst_length = '0;
  logic [PRIO_W-1:0]  job_priority = '0;
  logic               is_last = 1'b0;
  logic               busy;
  logic               result_valid;
  logic [ID_W-1:0]    out_job_id;
  logic [BURST_W-1:0] out_burst;
  logic [PRIO_W-1:0]  out_priority;
  logic [TIME_W-1:0]  wait_time;
  logic [TIME_W-1:0]  turnaround;
  logic [AVG_W-1:0]   avg_wait_q8;
  logic [AVG_W-1:0]   avg_turnaround_q8;
  logic               overflow;
  logic               row_last;

  // Rows the scheduler still owes us, oldest first.
  sched_row_t expected_rows [$];
  int mismatch_count = 0;
  // Percentage of cycles in which the sender holds its next request back.
  int idle_pct = 37;

  // Our own copy of the job store, refilled for every set.
  job_t job_store [SLOTS];
  int   stored_jobs = 0;
  bit   set_dropped = 1'b0;

  priority_schedule_timing dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .job_id(job_id),
    .burst_length(burst_length),
    .job_priority(job_priority),
    .is_last(is_last),
    .result_valid(result_valid),
    .out_job_id(out_job_id),
    .out_burst(out_burst),
    .out_priority(out_priority),
    .wait_time(wait_time),
    .turnaround(turnaround),
    .avg_wait_q8(avg_wait_q8),
    .avg_turnaround_q8(avg_turnaround_q8),
    .overflow(overflow),
    .row_last(row_last)
  );

  // 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Stores one accepted job (or notes that it was dropped) and, when the request
  // closes the set, works out the whole schedule. The order is a stable insertion
  // sort on the priority number, so equal priorities stay in arrival order. Waits
  // are running sums of the bursts served so far; the averages are the totals
  // shifted up by eight bits and divided by the job count, truncated.
  task automatic load_job_and_schedule(input job_t job, input logic last_flag,
                                       input bit keep_rows);
    int order [SLOTS];
    sched_row_t rows [SLOTS];
    int i;
    int j;
    int cur;
    int n;
    logic [63:0] elapsed;
    logic [63:0] finish_at;
    logic [63:0] total_wait;
    logic [63:0] total_turn;
    logic [63:0] avg;
    if (stored_jobs < SLOTS) begin
      job_store[stored_jobs] = job;
      stored_jobs++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!last_flag) return;

    n = stored_jobs;
    for (i = 0; i < n; i++) order[i] = i;
    for (i = 1; i < n; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && job_store[order[j-1]].prio > job_store[cur].prio) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end

    elapsed = '0;
    total_wait = '0;
    total_turn = '0;
    for (i = 0; i < n; i++) begin
      finish_at = elapsed + 64'(job_store[order[i]].burst);
      rows[i].id = job_store[order[i]].id;
      rows[i].burst = job_store[order[i]].burst;
      rows[i].prio = job_store[order[i]].prio;
      rows[i].wait_t = elapsed[TIME_W-1:0];
      rows[i].tat = finish_at[TIME_W-1:0];
      rows[i].avg_wait = '0;
      rows[i].avg_tat = '0;
      rows[i].ovf = set_dropped;
      rows[i].last = (i == n - 1);
      total_wait += elapsed;
      total_turn += finish_at;
      elapsed = finish_at;
    end
    if (n > 0) begin
      avg = (total_wait << FRAC_W) / 64'(n);
      rows[n-1].avg_wait = avg[AVG_W-1:0];
      avg = (total_turn << FRAC_W) / 64'(n);
      rows[n-1].avg_tat = avg[AVG_W-1:0];
    end
    if (keep_rows) begin
      for (i = 0; i < n; i++) expected_rows.push_back(rows[i]);
    end
    stored_jobs = 0;
    set_dropped = 1'b0;
  endtask

  // Offers one request. First the sender may sit idle for a random number of
  // cycles, with junk on the fields to show they are ignored while start is low.
  // Then start is raised and held until the block is not busy at a clock edge.
  // Everything is sampled at the rising edge, before the block's own updates land,
  // and every drive is a single nonblocking assignment per signal per edge.
  task automatic send_request(input job_t job, input logic last_flag);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      job_id <= ID_W'($urandom);
      burst_length <= BURST_W'($urandom);
      job_priority <= PRIO_W'($urandom);
      is_last <= 1'($urandom_range(1));
      @(posedge clk);
    end
    start <= 1'b1;
    job_id <= job.id;
    burst_length <= job.burst;
    job_priority <= job.prio;
    is_last <= last_flag;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Result checking. A row is on the ports for exactly one cycle, marked by
  // result_valid, and the block cannot be held off, so every edge with the strobe
  // high consumes the oldest expected row.
  always @(posedge clk) begin : check_rows
    sched_row_t got;
    sched_row_t want;
    if (!rst && result_valid) begin
      got = '{out_job_id, out_burst, out_priority, wait_time, turnaround,
              avg_wait_q8, avg_turnaround_q8, overflow, row_last};
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row, job id", 32'(got.id), 32'h0);
      end else begin
        want = expected_rows.pop_front();
        if (got.id !== want.id) report_mismatch("out_job_id", 32'(got.id), 32'(want.id));
        if (got.burst !== want.burst)
          report_mismatch("out_burst", 32'(got.burst), 32'(want.burst));
        if (got.prio !== want.prio)
          report_mismatch("out_priority", 32'(got.prio), 32'(want.prio));
        if (got.wait_t !== want.wait_t)
          report_mismatch("wait_time", 32'(got.wait_t), 32'(want.wait_t));
        if (got.tat !== want.tat)
          report_mismatch("turnaround", 32'(got.tat), 32'(want.tat));
        if (got.avg_wait !== want.avg_wait)
          report_mismatch("avg_wait_q8", 32'(got.avg_wait), 32'(want.avg_wait));
        if (got.avg_tat !== want.avg_tat)
          report_mismatch("avg_turnaround_q8", 32'(got.avg_tat), 32'(want.avg_tat));
        if (got.ovf !== want.ovf)
          report_mismatch("overflow", 32'(got.ovf), 32'(want.ovf));
        if (got.last !== want.last)
          report_mismatch("row_last", 32'(got.last), 32'(want.last));
      end
    end
  end

  initial begin : stimulus
    int i;
    int set_len;
    int kind;
    int drain;
    int jobs_sent;
    bit tie_heavy;
    job_t job;
    jobs_sent = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Hand-written rows go straight into the queue; the model
    // still sees every request so that its job count stays in step.
    for (i = 0; i < DIRECTED_N; i++) begin
      send_request(DIRECTED_REQS[i].job, DIRECTED_REQS[i].last);
      if (DIRECTED_REQS[i].typed) expected_rows.push_back(DIRECTED_REQS[i].row);
      load_job_and_schedule(DIRECTED_REQS[i].job, DIRECTED_REQS[i].last,
                            !DIRECTED_REQS[i].typed);
    end

    // Random sets. Most are short, since each job adds a pass over the whole set;
    // some fill the store exactly, and some run past it with the closing request
    // among the dropped ones. Half the sets draw priorities from a tiny range so
    // ties are common, the rest use the full range. Bursts hit both extremes now
    // and then. The sender idles 37% of the time for the first third of the jobs,
    // 57% for the second third, and not at all for the rest.
    while (jobs_sent < RANDOM_JOBS) begin
      kind = $urandom_range(99);
      if (kind < 10) set_len = SLOTS + $urandom_range(4, 1);
      else if (kind < 22) set_len = SLOTS;
      else if (kind < 40) set_len = $urandom_range(SLOTS - 1, 9);
      else set_len = $urandom_range(8, 1);
      tie_heavy = 1'($urandom_range(1));
      for (i = 0; i < set_len; i++) begin
        job.id = ID_W'($urandom);
        if ($urandom_range(7) == 0) job.burst = $urandom_range(1) ? '1 : '0;
        else job.burst = BURST_W'($urandom);
        job.prio = tie_heavy ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
        if (jobs_sent < RANDOM_JOBS / 3) idle_pct = 37;
        else if (jobs_sent < 2 * RANDOM_JOBS / 3) idle_pct = 57;
        else idle_pct = 0;
        send_request(job, i == set_len - 1);
        load_job_and_schedule(job, i == set_len - 1, 1'b1);
        if (i < SLOTS) jobs_sent++;
      end
    end
    start <= 1'b0;

    // Let the last schedule come out, then give the block time to show any
    // stray rows before judging.
    drain = 0;
    while (expected_rows.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_rows.size() != 0) begin
      report_mismatch("rows never produced, count", 32'(expected_rows.size()), 32'h0);
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog: ends the run as failed if the stimulus never finishes.
  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
